// ----- rtl/core/companion_power_mode_sequencer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Companion power mode sequencer assertion macros
// Shorthand for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef COMPANION_POWER_MODE_SEQUENCER_UNIT_MACROS_SVH
`define COMPANION_POWER_MODE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CPMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpms check failed");

// Next-cycle implication, checked out of reset.
`define CPMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpms check failed");

`endif

// ----- rtl/core/cpms_pkg.sv -----
// ----------------------------------------------------------------------------
// Companion power mode sequencer package
// Shared widths, command and pending codes, reset values.
// ----------------------------------------------------------------------------
package cpms_pkg;

    localparam int unsigned TICK_W   = 10;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CODE_W   = 3;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0]  TICK_PERIOD_RST = TICK_W'(10);
    localparam logic [LIMIT_W-1:0] HB_LIMIT_RST    = LIMIT_W'(1000);

    // request kinds
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    // command codes
    localparam logic [CODE_W-1:0] CMD_ABORT    = 3'd0;
    localparam logic [CODE_W-1:0] CMD_MOVE     = 3'd1;
    localparam logic [CODE_W-1:0] CMD_BOOT     = 3'd2;
    localparam logic [CODE_W-1:0] CMD_SHUTDOWN = 3'd3;
    localparam logic [CODE_W-1:0] CMD_RECOVER  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HB_LIMIT    = 1'd1;

    typedef enum logic [CODE_W-1:0] {
        PEND_NONE,
        PEND_ABORT,
        PEND_MOVE,
        PEND_BOOT,
        PEND_SHUTDOWN,
        PEND_RECOVER
    } pend_t;

    typedef struct packed {
        logic [CODE_W-1:0] mode;
        logic [CODE_W-1:0] pending;
        logic [CODE_W-1:0] saved_mode;
        logic              accepted;
        logic [CODE_W-1:0] led_color;
        logic              boot_strobe;
        logic              shutdown_strobe;
        logic              force_off_strobe;
        logic              storage_off_strobe;
        logic              heartbeat;
        logic [TIME_W-1:0] heartbeat_time;
    } result_t;

endpackage

// ----- rtl/core/cpms_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Tick and command items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpms_req_if;

    logic        valid;
    logic        ready;
    logic        req_type;
    logic [2:0]  command;
    logic [31:0] time_ms;
    logic        companion_ready;
    logic        companion_down;

    modport source (
        output valid, req_type, command, time_ms, companion_ready, companion_down,
        input  ready
    );

    modport sink (
        input  valid, req_type, command, time_ms, companion_ready, companion_down,
        output ready
    );

endinterface

// ----- rtl/core/cpms_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// One result item per request item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpms_rsp_if;

    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [2:0]  pending;
    logic [2:0]  saved_mode;
    logic        accepted;
    logic [2:0]  led_color;
    logic        boot_strobe;
    logic        shutdown_strobe;
    logic        force_off_strobe;
    logic        storage_off_strobe;
    logic        heartbeat;
    logic [31:0] heartbeat_time;

    modport source (
        output valid, mode, pending, saved_mode, accepted, led_color, boot_strobe,
               shutdown_strobe, force_off_strobe, storage_off_strobe, heartbeat,
               heartbeat_time,
        input  ready
    );

    modport sink (
        input  valid, mode, pending, saved_mode, accepted, led_color, boot_strobe,
               shutdown_strobe, force_off_strobe, storage_off_strobe, heartbeat,
               heartbeat_time,
        output ready
    );

endinterface

// ----- rtl/core/cpms_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpms_cfg_if;

    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

// ----- rtl/core/companion_power_mode_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// Companion power mode sequencer
// Sequences companion computer power through idle, boot, compute, shutdown
// and abort; latches commands, runs one mode step per tick, emits heartbeats.
// ----------------------------------------------------------------------------
// Takes one item per clock unless stalled; the result comes the cycle after
// acceptance. The mode logic, command check and heartbeat add/compare sit in
// a single pass ahead of the result register; that register frees the
// request side, so a new item is taken whenever the result slot is empty or
// being drained in the same cycle. Configuration writes are always ready.
module companion_power_mode_sequencer_unit
    import cpms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cpms_req_if.sink  req,
    cpms_rsp_if.source rsp,
    cpms_cfg_if.sink  cfg
);

    typedef enum logic [CODE_W-1:0] {
        MODE_IDLE,
        MODE_BOOT,
        MODE_COMPUTE,
        MODE_SHUTDOWN,
        MODE_ABORT
    } mode_t;

    mode_t              mode_reg, mode_next;
    pend_t              pend_reg, pend_next;
    logic [CODE_W-1:0]  saved_reg, saved_next;
    logic [LIMIT_W-1:0] accum_reg, accum_next;
    logic [TICK_W-1:0]  tick_period_reg;
    logic [LIMIT_W-1:0] hb_limit_reg;
    result_t            res_reg, res_next;
    logic               rsp_valid_reg;
    logic               req_acc;
    logic [LIMIT_W:0]   hb_sum;
    pend_t              cmd_pend;
    logic               cmd_known;
    logic               cmd_allowed;
    logic               abort_tick;
    logic               abort_seen;
    logic               cmd_quiet;
    logic               boot_entry;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_acc   = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cmd_known = 1'b1;
        cmd_pend  = PEND_NONE;
        unique case (req.command)
            CMD_ABORT:    cmd_pend = PEND_ABORT;
            CMD_MOVE:     cmd_pend = PEND_MOVE;
            CMD_BOOT:     cmd_pend = PEND_BOOT;
            CMD_SHUTDOWN: cmd_pend = PEND_SHUTDOWN;
            CMD_RECOVER:  cmd_pend = PEND_RECOVER;
            default:      cmd_known = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_IDLE:    cmd_allowed = (cmd_pend == PEND_MOVE) || (cmd_pend == PEND_BOOT);
            MODE_COMPUTE: cmd_allowed = (cmd_pend == PEND_SHUTDOWN);
            MODE_ABORT:   cmd_allowed = (cmd_pend == PEND_RECOVER);
            default:      cmd_allowed = 1'b0;
        endcase
    end

    assign hb_sum = {1'b0, accum_reg} + {{(LIMIT_W + 1 - TICK_W){1'b0}}, tick_period_reg};

    always_comb
    begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        saved_next = saved_reg;
        accum_next = accum_reg;
        res_next   = '0;

        if (req.req_type == REQ_COMMAND)
        begin
            if (cmd_known && cmd_pend == PEND_ABORT)
            begin
                pend_next         = PEND_ABORT;
                res_next.accepted = 1'b1;
            end
            else if (cmd_known && pend_reg == PEND_NONE && cmd_allowed)
            begin
                pend_next         = cmd_pend;
                res_next.accepted = 1'b1;
            end
        end
        else
        begin
            if (hb_sum > {1'b0, hb_limit_reg})
            begin
                res_next.heartbeat      = 1'b1;
                res_next.heartbeat_time = req.time_ms;
                accum_next              = '0;
            end
            else
            begin
                accum_next = hb_sum[LIMIT_W-1:0];
            end

            if (pend_reg == PEND_ABORT)
            begin
                saved_next                  = mode_reg;
                mode_next                   = MODE_ABORT;
                res_next.force_off_strobe   = 1'b1;
                res_next.storage_off_strobe = 1'b1;
                pend_next                   = PEND_NONE;
            end

            unique case (mode_next)
                MODE_IDLE:
                begin
                    if (pend_next == PEND_BOOT)
                    begin
                        mode_next            = MODE_BOOT;
                        res_next.boot_strobe = 1'b1;
                        pend_next            = PEND_NONE;
                    end
                end
                MODE_BOOT:
                begin
                    if (req.companion_ready)
                        mode_next = MODE_COMPUTE;
                end
                MODE_COMPUTE:
                begin
                    if (pend_next == PEND_SHUTDOWN)
                    begin
                        mode_next                = MODE_SHUTDOWN;
                        res_next.shutdown_strobe = 1'b1;
                        pend_next                = PEND_NONE;
                    end
                end
                MODE_SHUTDOWN:
                begin
                    res_next.shutdown_strobe = 1'b1;
                    if (req.companion_down)
                    begin
                        mode_next                   = MODE_IDLE;
                        res_next.force_off_strobe   = 1'b1;
                        res_next.storage_off_strobe = 1'b1;
                    end
                end
                MODE_ABORT:
                begin
                    if (pend_next == PEND_RECOVER)
                    begin
                        mode_next                   = MODE_IDLE;
                        res_next.force_off_strobe   = 1'b1;
                        res_next.storage_off_strobe = 1'b1;
                        pend_next                   = PEND_NONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res_next.mode       = mode_next;
        res_next.led_color  = mode_next;
        res_next.pending    = pend_next;
        res_next.saved_mode = saved_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            pend_reg        <= PEND_NONE;
            saved_reg       <= '0;
            accum_reg       <= '0;
            tick_period_reg <= TICK_PERIOD_RST;
            hb_limit_reg    <= HB_LIMIT_RST;
            rsp_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_TICK_PERIOD: tick_period_reg <= cfg.data[TICK_W-1:0];
                    REG_HB_LIMIT:    hb_limit_reg    <= cfg.data[LIMIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (req_acc)
            begin
                mode_reg      <= mode_next;
                pend_reg      <= pend_next;
                saved_reg     <= saved_next;
                accum_reg     <= accum_next;
                res_reg       <= res_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.mode               = res_reg.mode;
    assign rsp.pending            = res_reg.pending;
    assign rsp.saved_mode         = res_reg.saved_mode;
    assign rsp.accepted           = res_reg.accepted;
    assign rsp.led_color          = res_reg.led_color;
    assign rsp.boot_strobe        = res_reg.boot_strobe;
    assign rsp.shutdown_strobe    = res_reg.shutdown_strobe;
    assign rsp.force_off_strobe   = res_reg.force_off_strobe;
    assign rsp.storage_off_strobe = res_reg.storage_off_strobe;
    assign rsp.heartbeat          = res_reg.heartbeat;
    assign rsp.heartbeat_time     = res_reg.heartbeat_time;

    assign abort_tick = req_acc && (req.req_type == REQ_TICK) && (pend_reg == PEND_ABORT);
    assign abort_seen = (res_reg.mode == MODE_ABORT) && res_reg.force_off_strobe;
    assign cmd_quiet  = !res_reg.heartbeat && !res_reg.boot_strobe && !res_reg.shutdown_strobe;
    assign boot_entry = (res_reg.mode == MODE_BOOT) && (res_reg.pending == PEND_NONE);

`include "companion_power_mode_sequencer_unit_macros.svh"

    // a pending abort is always taken by the next tick
    `CPMS_ASSERT_NEXT(a_abort_taken, abort_tick, rsp_valid_reg && abort_seen)
    // accepted command items drive no heartbeat and no boot or shutdown strobe
    `CPMS_ASSERT_SAME(a_cmd_quiet, rsp_valid_reg && res_reg.accepted, cmd_quiet)
    // boot strobe only on entry to boot
    `CPMS_ASSERT_SAME(a_boot_entry, rsp_valid_reg && res_reg.boot_strobe, boot_entry)

endmodule

// ----- tb/sv/cpms_result_checker.sv -----
// ----------------------------------------------------------------------------
// Companion power mode sequencer result checker
// Watches the request, result and configuration channels, keeps its own copy
// of the mode, pending command, saved mode, heartbeat accumulator and
// settings, and compares every result item field by field, in order, with
// the one predicted for the request item that caused it.
// ----------------------------------------------------------------------------
module cpms_result_checker
    import cpms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cpms_req_if         req,
    cpms_rsp_if         rsp,
    cpms_cfg_if         cfg,
    output int unsigned fail_count,
    output int unsigned results_due
);

    typedef enum logic [CODE_W-1:0] {
        MODE_IDLE,
        MODE_BOOT,
        MODE_COMPUTE,
        MODE_SHUTDOWN,
        MODE_ABORT
    } mode_t;

    mode_t              mode_st;
    mode_t              saved_st;
    pend_t              pend_st;
    logic [LIMIT_W-1:0] accum_st;
    logic [TICK_W-1:0]  tick_cfg;
    logic [LIMIT_W-1:0] limit_cfg;
    result_t            expected_results[$];

    function automatic logic cmd_permitted(input mode_t m, input pend_t p);
        case (m)
            MODE_IDLE:    return p == PEND_MOVE || p == PEND_BOOT;
            MODE_COMPUTE: return p == PEND_SHUTDOWN;
            MODE_ABORT:   return p == PEND_RECOVER;
            default:      return 1'b0;
        endcase
    endfunction

    // advances the tracked state by one item and returns its result
    function automatic result_t next_sequencer_result(
        input logic              rt,
        input logic [CODE_W-1:0] code,
        input logic [TIME_W-1:0] now,
        input logic              rdy,
        input logic              dn
    );
        result_t          r;
        pend_t            want;
        logic [LIMIT_W:0] sum;
        r = '0;
        if (rt == REQ_COMMAND)
        begin
            if (code <= CMD_RECOVER)
            begin
                want = pend_t'(code + 3'd1);
                if (want == PEND_ABORT)
                begin
                    pend_st    = PEND_ABORT;
                    r.accepted = 1'b1;
                end
                else if (pend_st == PEND_NONE && cmd_permitted(mode_st, want))
                begin
                    pend_st    = want;
                    r.accepted = 1'b1;
                end
            end
        end
        else
        begin
            sum = (LIMIT_W+1)'(accum_st) + (LIMIT_W+1)'(tick_cfg);
            if (sum > (LIMIT_W+1)'(limit_cfg))
            begin
                r.heartbeat      = 1'b1;
                r.heartbeat_time = now;
                accum_st         = '0;
            end
            else
            begin
                accum_st = sum[LIMIT_W-1:0];
            end
            if (pend_st == PEND_ABORT)
            begin
                saved_st             = mode_st;
                mode_st              = MODE_ABORT;
                r.force_off_strobe   = 1'b1;
                r.storage_off_strobe = 1'b1;
                pend_st              = PEND_NONE;
            end
            case (mode_st)
                MODE_IDLE:
                begin
                    if (pend_st == PEND_BOOT)
                    begin
                        mode_st       = MODE_BOOT;
                        r.boot_strobe = 1'b1;
                        pend_st       = PEND_NONE;
                    end
                end
                MODE_BOOT:
                begin
                    if (rdy)
                        mode_st = MODE_COMPUTE;
                end
                MODE_COMPUTE:
                begin
                    if (pend_st == PEND_SHUTDOWN)
                    begin
                        mode_st           = MODE_SHUTDOWN;
                        r.shutdown_strobe = 1'b1;
                        pend_st           = PEND_NONE;
                    end
                end
                MODE_SHUTDOWN:
                begin
                    r.shutdown_strobe = 1'b1;
                    if (dn)
                    begin
                        mode_st              = MODE_IDLE;
                        r.force_off_strobe   = 1'b1;
                        r.storage_off_strobe = 1'b1;
                    end
                end
                MODE_ABORT:
                begin
                    if (pend_st == PEND_RECOVER)
                    begin
                        mode_st              = MODE_IDLE;
                        r.force_off_strobe   = 1'b1;
                        r.storage_off_strobe = 1'b1;
                        pend_st              = PEND_NONE;
                    end
                end
                default: ;
            endcase
        end
        r.mode       = mode_st;
        r.pending    = pend_st;
        r.saved_mode = saved_st;
        r.led_color  = mode_st;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
                               input logic [TIME_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            mode_st     = MODE_IDLE;
            saved_st    = MODE_IDLE;
            pend_st     = PEND_NONE;
            accum_st    = '0;
            tick_cfg    = TICK_PERIOD_RST;
            limit_cfg   = HB_LIMIT_RST;
            fail_count  = 0;
            results_due = 0;
            expected_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.mode, rsp.pending, rsp.saved_mode, rsp.accepted, rsp.led_color,
                       rsp.boot_strobe, rsp.shutdown_strobe, rsp.force_off_strobe,
                       rsp.storage_off_strobe, rsp.heartbeat, rsp.heartbeat_time};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result item with none expected: %p", $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("mode", TIME_W'(want.mode), TIME_W'(got.mode));
                    check_field("pending", TIME_W'(want.pending), TIME_W'(got.pending));
                    check_field("saved_mode", TIME_W'(want.saved_mode),
                                TIME_W'(got.saved_mode));
                    check_field("accepted", TIME_W'(want.accepted), TIME_W'(got.accepted));
                    check_field("led_color", TIME_W'(want.led_color),
                                TIME_W'(got.led_color));
                    check_field("boot_strobe", TIME_W'(want.boot_strobe),
                                TIME_W'(got.boot_strobe));
                    check_field("shutdown_strobe", TIME_W'(want.shutdown_strobe),
                                TIME_W'(got.shutdown_strobe));
                    check_field("force_off_strobe", TIME_W'(want.force_off_strobe),
                                TIME_W'(got.force_off_strobe));
                    check_field("storage_off_strobe", TIME_W'(want.storage_off_strobe),
                                TIME_W'(got.storage_off_strobe));
                    check_field("heartbeat", TIME_W'(want.heartbeat),
                                TIME_W'(got.heartbeat));
                    check_field("heartbeat_time", want.heartbeat_time, got.heartbeat_time);
                end
            end
            if (req.valid && req.ready)
                expected_results.push_back(next_sequencer_result(req.req_type, req.command,
                    req.time_ms, req.companion_ready, req.companion_down));
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_TICK_PERIOD)
                    tick_cfg = cfg.data[TICK_W-1:0];
                else
                    limit_cfg = cfg.data;
            end
            results_due = expected_results.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Companion power mode sequencer testbench
// Drives tick and command items through directed cases and then randomised
// power cycles (boot, compute, shutdown, with aborts and recovery mixed in)
// over several heartbeat settings, with random stalls on both channels in most phases. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module testbench
    import cpms_pkg::*;
;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned LONG_HOLD      = 200;
    localparam int unsigned PHASE_ITEMS    = 200;
    localparam int unsigned NUM_PHASES     = 7;

    // command codes outside the defined set
    localparam logic [CODE_W-1:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [CODE_W-1:0] CMD_UNKNOWN_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned results_due;
    int unsigned items_sent;
    bit          req_gaps;
    bit          rsp_gaps;
    bit          long_hold;
    int          step_no;
    int          abort_at;

    cpms_req_if req ();
    cpms_rsp_if rsp ();
    cpms_cfg_if cfg ();

    companion_power_mode_sequencer_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    cpms_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
                rsp.ready <= 1'b1;
            end
            else if (rsp_gaps && $urandom_range(0, 7) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                rsp.ready <= 1'b1;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [CODE_W-1:0] any_code();
        return CODE_W'($urandom_range(0, 7));
    endfunction

    task automatic send_item(input logic rt, input logic [CODE_W-1:0] code,
                             input logic [TIME_W-1:0] now, input logic rdy, input logic dn);
        if (req_gaps && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        req.valid           <= 1'b1;
        req.req_type        <= rt;
        req.command         <= code;
        req.time_ms         <= now;
        req.companion_ready <= rdy;
        req.companion_down  <= dn;
        do @(posedge clk); while (!req.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_tick(input logic rdy, input logic dn);
        send_item(REQ_TICK, any_code(), $urandom, rdy, dn);
    endtask

    task automatic send_command(input logic [CODE_W-1:0] code);
        send_item(REQ_COMMAND, code, $urandom, coin(), coin());
    endtask

    // one step of a power cycle; an abort and recovery may cut in first
    task automatic cycle_step(input logic rt, input logic [CODE_W-1:0] code,
                              input logic rdy, input logic dn);
        if (step_no == abort_at)
        begin
            send_command(CMD_ABORT);
            repeat ($urandom_range(1, 3)) send_tick(coin(), coin());
            send_command(CMD_RECOVER);
        end
        step_no++;
        if (rt == REQ_TICK)
            send_tick(rdy, dn);
        else
            send_command(code);
    endtask

    // wait for every result item, then let the block settle
    task automatic drain();
        req.valid <= 1'b0;
        do @(negedge clk); while (results_due != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] tick_data,
                                input logic [CFG_DATA_W-1:0] limit_data);
        cfg.valid <= 1'b1;
        cfg.index <= REG_TICK_PERIOD;
        cfg.data  <= tick_data;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.index <= REG_HB_LIMIT;
        cfg.data  <= limit_data;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int  phase;
        int  n_wait;
        int  n_run;
        int  n_down;
        bit  paused;
        req.valid           = 1'b0;
        req.req_type        = REQ_TICK;
        req.command         = CMD_ABORT;
        req.time_ms         = '0;
        req.companion_ready = 1'b0;
        req.companion_down  = 1'b0;
        cfg.valid           = 1'b0;
        cfg.index           = REG_TICK_PERIOD;
        cfg.data            = '0;
        req_gaps            = 1'b1;
        rsp_gaps            = 1'b1;
        long_hold           = 1'b0;
        items_sent          = 0;
        paused              = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);

        // directed: ignored fields, refused and unknown commands, full cycle
        send_item(REQ_TICK, CMD_ABORT, 32'h0000_0000, 1'b0, 1'b0);
        send_item(REQ_TICK, CMD_RECOVER, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_command(CMD_UNKNOWN_LO);
        send_command(CMD_UNKNOWN_HI);
        send_command(CMD_SHUTDOWN);
        send_command(CMD_RECOVER);
        send_command(CMD_MOVE);
        send_command(CMD_BOOT);
        send_tick(1'b1, 1'b1);
        send_command(CMD_ABORT);
        send_command(CMD_ABORT);
        send_tick(1'b0, 1'b0);
        send_command(CMD_BOOT);
        send_command(CMD_RECOVER);
        send_tick(1'b0, 1'b0);
        send_command(CMD_BOOT);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_command(CMD_SHUTDOWN);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_command(CMD_BOOT);
        send_tick(1'b0, 1'b0);
        send_command(CMD_ABORT);
        send_tick(1'b1, 1'b0);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                case (phase)
                    1: write_config(16'd1000, 16'd1);
                    2: write_config(16'd1, 16'd60000);
                    3: write_config(16'd1023, 16'd65535);
                    4: write_config(16'd0, 16'd0);
                    5: write_config(CFG_DATA_W'($urandom),
                                    CFG_DATA_W'($urandom_range(0, 2000)));
                    default: write_config(16'd7, 16'd50);
                endcase
            end
            req_gaps = (phase != 3) && (phase != NUM_PHASES - 1);
            rsp_gaps = (phase != NUM_PHASES - 1);
            if (phase == 2)
                long_hold = 1'b1;
            while (items_sent < (phase + 1) * PHASE_ITEMS)
            begin
                if (phase == 4 && !paused && items_sent >= 4 * PHASE_ITEMS + 100)
                begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    send_item(coin(), any_code(), $urandom, coin(), coin());
                end
                else
                begin
                    n_wait   = $urandom_range(0, 4);
                    n_run    = $urandom_range(0, 4);
                    n_down   = $urandom_range(0, 4);
                    step_no  = 0;
                    abort_at = ($urandom_range(0, 3) == 0) ?
                               int'($urandom_range(0, n_wait + n_run + n_down + 6)) : -1;
                    cycle_step(REQ_COMMAND, CMD_BOOT, 1'b0, 1'b0);
                    cycle_step(REQ_TICK, CMD_ABORT, 1'b0, coin());
                    repeat (n_wait) cycle_step(REQ_TICK, CMD_ABORT, 1'b0, coin());
                    cycle_step(REQ_TICK, CMD_ABORT, 1'b1, coin());
                    repeat (n_run) cycle_step(REQ_TICK, CMD_ABORT, coin(), coin());
                    cycle_step(REQ_COMMAND, CMD_SHUTDOWN, 1'b0, 1'b0);
                    cycle_step(REQ_TICK, CMD_ABORT, coin(), 1'b0);
                    repeat (n_down) cycle_step(REQ_TICK, CMD_ABORT, coin(), 1'b0);
                    cycle_step(REQ_TICK, CMD_ABORT, coin(), 1'b1);
                end
            end
        end

        drain();
        if (fail_count == 0 && results_due == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/cpms_pkg.sv
rtl/core/cpms_req_if.sv
rtl/core/cpms_rsp_if.sv
rtl/core/cpms_cfg_if.sv
rtl/core/companion_power_mode_sequencer_unit.sv
tb/sv/cpms_result_checker.sv
tb/sv/testbench.sv
